### design/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_REAR  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REM_REAR  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PEEK      = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CHAIN_HOLD   = 2'd0,
    CHAIN_PUSH   = 2'd1,
    CHAIN_POP    = 2'd2,
    CHAIN_APPEND = 2'd3
  } chain_op_t;

endpackage

### design/dq_if.sv
// Command and result channel interfaces of the double-ended queue.
interface dq_cmd_if import dq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface dq_res_if import dq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  front_value;
  logic signed [VALUE_W-1:0]  rear_value;
  logic [COUNT_W-1:0]         item_count;
  logic                       is_empty;

  modport source (output valid, output status, output front_value, output rear_value,
                  output item_count, output is_empty, input ready);
  modport sink (input valid, input status, input front_value, input rear_value,
                input item_count, input is_empty, output ready);
endinterface

### design/dq_cell.sv
// One storage cell of a deque chain, fed by its two neighbours.
module dq_cell import dq_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  chain_op_t             op,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  input  logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    case (op)
      CHAIN_PUSH: begin
        data <= left;
      end
      CHAIN_POP: begin
        data <= right;
      end
      CHAIN_APPEND: begin
        if (count == SLOT) begin
          data <= value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### design/dq_chain.sv
// A row of deque cells whose head sits at cell zero.
module dq_chain import dq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  chain_op_t             op,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] head
);

  logic [DATA_WIDTH-1:0] cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = value;
    end else begin : g_inner_left
      assign left = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_right
      assign right = cells[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk   (clk),
      .op    (op),
      .count (count),
      .left  (left),
      .right (right),
      .value (value),
      .data  (cells[i])
    );
  end

  assign head = cells[0];

endmodule

### design/double_ended_queue.sv
// Bounded double-ended queue built from two mirrored chains of cells.
// The result of an action is registered and presented in the cycle after its command beat.
// One action per cycle while results are taken; both chains shift or write in the same cycle.
// The front is read at the head of the forward chain, the rear at the head of the reverse chain.
// Reset clears the element count and the result valid flag; cell contents are not reset.
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  dq_cmd_if.sink   cmd,
  dq_res_if.source res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  status_t                       status;
  status_t                       status_next;
  logic                          res_valid;
  logic                          cmd_acc;
  logic                          empty;
  chain_op_t                     fwd_op;
  chain_op_t                     rev_op;
  logic [DATA_WIDTH-1:0]         store_value;
  logic [DATA_WIDTH-1:0]         fwd_head;
  logic [DATA_WIDTH-1:0]         rev_head;
  logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] front_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] rear_ext;
  logic [CNT_W+COUNT_W-1:0]      count_ext;

  assign cmd.ready   = !res_valid || res.ready;
  assign cmd_acc     = cmd.valid && cmd.ready;
  assign value_ext   = {{DATA_WIDTH{cmd.value[VALUE_W-1]}}, cmd.value};
  assign store_value = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    fwd_op      = CHAIN_HOLD;
    rev_op      = CHAIN_HOLD;
    if (cmd_acc) begin
      unique case (cmd.action)
        ACT_INS_FRONT: begin
          if (count == FULL_COUNT) begin
            status_next = ST_FULL;
          end else begin
            fwd_op     = CHAIN_PUSH;
            rev_op     = CHAIN_APPEND;
            count_next = count + ONE_COUNT;
          end
        end
        ACT_INS_REAR: begin
          if (count == FULL_COUNT) begin
            status_next = ST_FULL;
          end else begin
            fwd_op     = CHAIN_APPEND;
            rev_op     = CHAIN_PUSH;
            count_next = count + ONE_COUNT;
          end
        end
        ACT_REM_FRONT: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            fwd_op     = CHAIN_POP;
            count_next = count - ONE_COUNT;
          end
        end
        ACT_REM_REAR: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            rev_op     = CHAIN_POP;
            count_next = count - ONE_COUNT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd_acc) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      status <= status_next;
    end
  end

  dq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_fwd_chain (
    .clk   (clk),
    .op    (fwd_op),
    .count (count),
    .value (store_value),
    .head  (fwd_head)
  );

  dq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_rev_chain (
    .clk   (clk),
    .op    (rev_op),
    .count (count),
    .value (store_value),
    .head  (rev_head)
  );

  assign empty     = (count == '0);
  assign front_ext = {{VALUE_W{fwd_head[DATA_WIDTH-1]}}, fwd_head};
  assign rear_ext  = {{VALUE_W{rev_head[DATA_WIDTH-1]}}, rev_head};
  assign count_ext = {{COUNT_W{1'b0}}, count};

  assign res.valid       = res_valid;
  assign res.status      = status;
  assign res.front_value = empty ? '0 : front_ext[VALUE_W-1:0];
  assign res.rear_value  = empty ? '0 : rear_ext[VALUE_W-1:0];
  assign res.item_count  = count_ext[COUNT_W-1:0];
  assign res.is_empty    = empty;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("Element count exceeds the depth.");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && (cmd.action == ACT_INS_FRONT || cmd.action == ACT_INS_REAR) &&
    count == FULL_COUNT |=> res_valid && status == ST_FULL && count == FULL_COUNT)
    else $error("Insert on a full deque did not report full or changed the count.");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && (cmd.action == ACT_REM_FRONT || cmd.action == ACT_REM_REAR) &&
    count == '0 |=> res_valid && status == ST_EMPTY && count == '0)
    else $error("Remove on an empty deque did not report empty or changed the count.");

  a_single_heads: assert property (@(posedge clk) disable iff (rst)
    count == ONE_COUNT |-> fwd_head == rev_head)
    else $error("Forward and reverse chains disagree on a single element.");
`endif

endmodule

### tb/sv/deque_checker.sv
// Checker that predicts every deque result and compares it with the result channel.
module deque_checker import dq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  dq_cmd_if    cmd,
  dq_res_if    res,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic [COUNT_W-1:0]        item_count;
    logic                      is_empty;
  } outcome_t;

  logic signed [VALUE_W-1:0] deque_slot [DEPTH];
  int                        head_slot;
  int                        fill_level;
  outcome_t                  expected_outcomes [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic apply_action(input logic [ACTION_W-1:0] act,
                              input logic signed [VALUE_W-1:0] val);
    outcome_t o;
    o.status      = ST_OK;
    o.front_value = '0;
    o.rear_value  = '0;
    case (act)
      ACT_INS_FRONT, ACT_INS_REAR: begin
        if (fill_level >= DEPTH) begin
          o.status = ST_FULL;
        end else if (act == ACT_INS_FRONT) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          deque_slot[head_slot] = val;
          fill_level++;
        end else begin
          deque_slot[(head_slot + fill_level) % DEPTH] = val;
          fill_level++;
        end
      end
      ACT_REM_FRONT, ACT_REM_REAR: begin
        if (fill_level == 0) begin
          o.status = ST_EMPTY;
        end else begin
          if (act == ACT_REM_FRONT) head_slot = (head_slot + 1) % DEPTH;
          fill_level--;
        end
      end
      default: ;
    endcase
    if (fill_level != 0) begin
      o.front_value = deque_slot[head_slot];
      o.rear_value  = deque_slot[(head_slot + fill_level - 1) % DEPTH];
    end
    o.item_count = COUNT_W'(fill_level);
    o.is_empty   = (fill_level == 0);
    expected_outcomes.push_back(o);
  endtask

  task automatic compare_result();
    outcome_t want;
    if (expected_outcomes.size() == 0) begin
      report_mismatch("result beat with no outstanding command");
    end else begin
      want = expected_outcomes.pop_front();
      if (res.status !== want.status)
        report_mismatch($sformatf("status got %0d, expected %0d", res.status, want.status));
      if (res.front_value !== want.front_value)
        report_mismatch($sformatf("front_value got %0h, expected %0h",
                                  res.front_value, want.front_value));
      if (res.rear_value !== want.rear_value)
        report_mismatch($sformatf("rear_value got %0h, expected %0h",
                                  res.rear_value, want.rear_value));
      if (res.item_count !== want.item_count)
        report_mismatch($sformatf("item_count got %0d, expected %0d",
                                  res.item_count, want.item_count));
      if (res.is_empty !== want.is_empty)
        report_mismatch($sformatf("is_empty got %0b, expected %0b",
                                  res.is_empty, want.is_empty));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_slot  = 0;
      fill_level = 0;
      expected_outcomes.delete();
    end else begin
      if (cmd.valid === 1'b1 && cmd.ready === 1'b1) apply_action(cmd.action, cmd.value);
      if (res.valid === 1'b1 && res.ready === 1'b1) compare_result();
    end
    pending <= expected_outcomes.size();
  end

endmodule

### tb/sv/tb_double_ended_queue.sv
// Top-level testbench of the double-ended queue: stimulus, result back-pressure and verdict.
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1450;
  localparam int MAX_GAP      = 12;

  localparam logic [ACTION_W-1:0] ACT_UNUSED_5 = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   cmd_calm;
  bit   res_calm;

  dq_cmd_if cmd_ch ();
  dq_res_if res_ch ();

  double_ended_queue #(.DEPTH(DEPTH), .DATA_WIDTH(VALUE_W)) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  deque_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_action(input logic [ACTION_W-1:0] act,
                             input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = draw_gap(cmd_calm);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.action <= act;
    cmd_ch.value  <= val;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
  endtask

  initial begin
    logic signed [VALUE_W-1:0] edge_values [8];
    mix_t                      mix;
    int                        burst_left;
    int                        ins_pct;
    int                        rem_pct;
    int                        r;
    logic [ACTION_W-1:0]       act;

    edge_values = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1,
                    32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'shFFFF_FFFE};
    cmd_ch.valid  <= 1'b0;
    cmd_ch.action <= ACT_PEEK;
    cmd_ch.value  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_action(ACT_REM_FRONT, 32'sh1234_5678);
    send_action(ACT_REM_REAR, '1);
    send_action(ACT_PEEK, '0);
    send_action(ACT_UNUSED_7, '1);
    for (int i = 0; i < DEPTH; i++)
      send_action(i % 2 ? ACT_INS_REAR : ACT_INS_FRONT, edge_values[i % 8]);
    send_action(ACT_INS_FRONT, 32'sh7FFF_FFFF);
    send_action(ACT_INS_REAR, 32'sh8000_0000);
    send_action(ACT_UNUSED_5, '0);
    send_action(ACT_REM_FRONT, '0);
    send_action(ACT_UNUSED_6, '0);
    send_action(ACT_REM_REAR, '0);

    mix        = MIX_DRAIN;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        mix        = mix_t'($urandom_range(0, 2));
        burst_left = $urandom_range(8, 40);
      end
      burst_left--;
      case (mix)
        MIX_FILL:  begin ins_pct = 75; rem_pct = 20; end
        MIX_DRAIN: begin ins_pct = 20; rem_pct = 75; end
        default:   begin ins_pct = 45; rem_pct = 45; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_pct) act = $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_REAR;
      else if (r < ins_pct + rem_pct) act = $urandom_range(0, 1) ? ACT_REM_FRONT : ACT_REM_REAR;
      else begin
        case ($urandom_range(0, 3))
          0:       act = ACT_UNUSED_5;
          1:       act = ACT_UNUSED_6;
          2:       act = ACT_UNUSED_7;
          default: act = ACT_PEEK;
        endcase
      end
      send_action(act, pick_value());
    end
    cmd_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap(res_calm);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
